### rtl/touch_frame_deframer_press_counter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the touch frame deframer
// Shared concurrent check forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TOUCH_FRAME_DEFRAMER_PRESS_COUNTER_CORE_MACROS_SVH
`define TOUCH_FRAME_DEFRAMER_PRESS_COUNTER_CORE_MACROS_SVH

// same-cycle implication
`define TFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg
// Types and fixed codes of the touch frame deframer.
// ----------------------------------------------------------------------------
package tfd_pkg;

   localparam logic [7:0] SYNC_BYTE       = 8'hFF;
   localparam logic [7:0] TOUCH_CMD       = 8'h01;
   localparam logic [7:0] TOUCH_LEN       = 8'h20;
   localparam logic [7:0] THRESHOLD_RESET = 8'd32;

   localparam logic [1:0] PH_CMD     = 2'd0;
   localparam logic [1:0] PH_LEN     = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_CHECK   = 2'd3;

   localparam logic KIND_ZONE  = 1'b0;
   localparam logic KIND_OTHER = 1'b1;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic        result_kind;
      logic [4:0]  zone_index;
      logic [31:0] press_count;
      logic        zone_pressed;
      logic [7:0]  packet_cmd;
      logic [7:0]  packet_len;
      logic        last;
   } rsp_payload_type;

   // frame end event from the byte parser to the counter walker
   typedef struct packed {
      logic       done;
      logic       touch;
      logic [7:0] cmd;
      logic [7:0] len;
   } frame_end_type;

endpackage

### rtl/tfd_chan_if.sv
// ----------------------------------------------------------------------------
// tfd_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface tfd_chan_if
   import tfd_pkg::*;
#(
   parameter type payload_type = req_payload_type
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/tfd_ram.sv
// ----------------------------------------------------------------------------
// tfd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/tfd_deframer.sv
// ----------------------------------------------------------------------------
// tfd_deframer
// Byte parser: sync hunt, command, length, payload verdicts, checksum.
// ----------------------------------------------------------------------------
`include "touch_frame_deframer_press_counter_core_macros.svh"

module tfd_deframer
   import tfd_pkg::*;
#(
   parameter int NUM_ZONES = 32,
   localparam int ZIW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   output frame_end_type        frame_end,
   output logic [NUM_ZONES-1:0] press_mask
);
   logic                 in_sync_ff, in_sync_in;
   logic [1:0]           phase_ff, phase_in;
   logic [7:0]           cmd_ff, cmd_in;
   logic [7:0]           len_ff, len_in;
   logic [7:0]           pos_ff, pos_in;
   logic [NUM_ZONES-1:0] mask_ff, mask_in;
   logic [7:0]           thr_ff;
   logic                 is_touch;
   logic [7:0]           bit_idx;

   assign is_touch = (cmd_ff == TOUCH_CMD) && (len_ff == TOUCH_LEN);
   // payload byte i maps to zone NUM_ZONES-1-i
   assign bit_idx  = 8'(NUM_ZONES - 1) - pos_ff;

   always_comb begin
      in_sync_in      = in_sync_ff;
      phase_in        = phase_ff;
      cmd_in          = cmd_ff;
      len_in          = len_ff;
      pos_in          = pos_ff;
      mask_in         = mask_ff;
      frame_end.done  = 1'b0;
      frame_end.touch = is_touch;
      frame_end.cmd   = cmd_ff;
      frame_end.len   = len_ff;
      if (accept) begin
         if (!in_sync_ff) begin
            if (rx_byte == SYNC_BYTE) begin
               in_sync_in = 1'b1;
               phase_in   = PH_CMD;
            end
         end else begin
            unique case (phase_ff)
               PH_CMD: begin
                  cmd_in   = rx_byte;
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  len_in   = rx_byte;
                  pos_in   = 8'd0;
                  mask_in  = '0;
                  phase_in = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  if (is_touch && (pos_ff < 8'(NUM_ZONES)) && (rx_byte >= thr_ff)) begin
                     mask_in[bit_idx[ZIW-1:0]] = 1'b1;
                  end
                  pos_in = pos_ff + 8'd1;
                  if (pos_in >= len_ff) begin
                     phase_in = PH_CHECK;
                  end
               end
               default: begin
                  // checksum byte: close the frame, drop back to hunting
                  in_sync_in     = 1'b0;
                  phase_in       = PH_CMD;
                  mask_in        = '0;
                  frame_end.done = 1'b1;
               end
            endcase
         end
      end
   end

   assign press_mask = mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sync_ff <= 1'b0;
         phase_ff   <= PH_CMD;
         cmd_ff     <= 8'd0;
         len_ff     <= 8'd0;
         pos_ff     <= 8'd0;
         mask_ff    <= '0;
         thr_ff     <= THRESHOLD_RESET;
      end else begin
         in_sync_ff <= in_sync_in;
         phase_ff   <= phase_in;
         cmd_ff     <= cmd_in;
         len_ff     <= len_in;
         pos_ff     <= pos_in;
         mask_ff    <= mask_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   `TFD_ASSERT_NEXT(a_end_unsyncs, clock, reset, frame_end.done, !in_sync_ff, "sync kept after frame end")
   `TFD_ASSERT_NOW(a_hunt_phase, clock, reset, !in_sync_ff, phase_ff == PH_CMD, "phase moved while hunting")
   `TFD_ASSERT_NOW(a_payload_pos, clock, reset, in_sync_ff && (phase_ff == PH_PAYLOAD), pos_ff < len_ff, "payload position past length")
endmodule

### rtl/tfd_walker.sv
// ----------------------------------------------------------------------------
// tfd_walker
// Walks the zone counter RAM at the end of a touch frame and drives the result register.
// ----------------------------------------------------------------------------
`include "touch_frame_deframer_press_counter_core_macros.svh"

module tfd_walker
   import tfd_pkg::*;
#(
   parameter int NUM_ZONES   = 32,
   parameter int COUNT_WIDTH = 32,
   localparam int ZIW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  frame_end_type        frame_end,
   input  logic [NUM_ZONES-1:0] press_mask,
   output logic                 ready,
   tfd_chan_if.source           rsp
);
   localparam logic W_IDLE = 1'b0;
   localparam logic W_RUN  = 1'b1;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
   localparam logic [ZIW-1:0] LAST_ZONE = ZIW'(NUM_ZONES - 1);

   logic                   state_ff, state_in;
   logic [ZIW-1:0]         zone_ff, zone_in;
   logic [NUM_ZONES-1:0]   mask_ff, mask_in;
   logic [7:0]             cmd_ff, cmd_in;
   logic [7:0]             len_ff, len_in;
   logic [NUM_ZONES-1:0]   valid_ff, valid_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;
   logic                   slot_free;
   logic                   rd_en, wr_en;
   logic [ZIW-1:0]         rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data, cur_cnt, new_cnt;
   logic                   pressed;
   logic [63:0]            cnt_wide;
   logic [6:0]             zone_wide;

   tfd_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_ZONES)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (zone_ff),
      .wr_data (new_cnt),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign ready     = (state_ff == W_IDLE) && slot_free;

   // never-written entries read as zero
   assign cur_cnt   = rd_valid_ff ? rd_data : '0;
   assign pressed   = mask_ff[zone_ff];
   assign new_cnt   = pressed ? ((cur_cnt == CMAX) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1)) : '0;
   assign cnt_wide  = 64'(new_cnt);
   assign zone_wide = 7'(zone_ff);

   always_comb begin
      state_in     = state_ff;
      zone_in      = zone_ff;
      mask_in      = mask_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      valid_in     = valid_ff;
      rd_valid_in  = rd_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = zone_ff;
      wr_en        = 1'b0;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         W_IDLE: begin
            if (frame_end.done) begin
               if (frame_end.touch) begin
                  mask_in  = press_mask;
                  cmd_in   = frame_end.cmd;
                  len_in   = frame_end.len;
                  zone_in  = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = W_RUN;
               end else begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.result_kind  = KIND_OTHER;
                  rsp_data_in.zone_index   = 5'd0;
                  rsp_data_in.press_count  = 32'd0;
                  rsp_data_in.zone_pressed = 1'b0;
                  rsp_data_in.packet_cmd   = frame_end.cmd;
                  rsp_data_in.packet_len   = frame_end.len;
                  rsp_data_in.last         = 1'b1;
               end
            end
         end
         default: begin
            // update one zone per free result slot, prefetch the next one
            if (slot_free) begin
               wr_en                    = 1'b1;
               valid_in[zone_ff]        = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_kind  = KIND_ZONE;
               rsp_data_in.zone_index   = zone_wide[4:0];
               rsp_data_in.press_count  = cnt_wide[31:0];
               rsp_data_in.zone_pressed = pressed;
               rsp_data_in.packet_cmd   = cmd_ff;
               rsp_data_in.packet_len   = len_ff;
               rsp_data_in.last         = (zone_ff == LAST_ZONE);
               if (zone_ff == LAST_ZONE) begin
                  state_in = W_IDLE;
               end else begin
                  zone_in = zone_ff + ZIW'(1);
                  rd_en   = 1'b1;
                  rd_addr = zone_in;
               end
            end
         end
      endcase
      if (rd_en) begin
         rd_valid_in = valid_ff[rd_addr];
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         zone_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         zone_ff      <= zone_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      cmd_ff      <= cmd_in;
      len_ff      <= len_in;
      rd_valid_ff <= rd_valid_in;
      rsp_data_ff <= rsp_data_in;
   end

   `TFD_ASSERT_NOW(a_start_idle, clock, reset, frame_end.done, (state_ff == W_IDLE) && slot_free, "frame end while walking or blocked")
   `TFD_ASSERT_NOW(a_write_in_run, clock, reset, wr_en, state_ff == W_RUN, "counter write outside walk")
   `TFD_ASSERT_NEXT(a_last_zone, clock, reset, (state_ff == W_RUN) && slot_free && (zone_ff == LAST_ZONE), (state_ff == W_IDLE) && rsp_valid_ff && rsp_data_ff.last, "walk did not end on last zone")
endmodule

### rtl/touch_frame_deframer_press_counter_core.sv
// ----------------------------------------------------------------------------
// touch_frame_deframer_press_counter_core
// Serial frame deframer with per-zone touch press counters.
// ----------------------------------------------------------------------------
// req_if carries one received byte per item; rsp_if carries result items.
// csr_wr_en/csr_wr_data write the touch threshold (reset value 32).
// Bytes outside a frame are dropped until the sync byte 0xFF. A frame is
// command, length, payload, checksum; nothing is emitted before the
// checksum byte.
// A checksum byte of a touch frame (command 1, length 32) starts a walk
// over the counter RAM: zone 0 is read first, then one zone per cycle while
// the result slot is free, through its one read and one write port; NUM_ZONES
// results follow, zone 0 first, the last one flagged. Any other frame gives
// one result the cycle after its checksum byte. No byte is taken during a
// walk.
// Reset drops sync, restores the threshold and marks all counters zero at
// once through per-zone valid bits; no clearing pass is needed.
// A stalled receiver holds the result register and the walk pauses with it;
// bytes are taken again once the result slot is free.
// ----------------------------------------------------------------------------
module touch_frame_deframer_press_counter_core
   import tfd_pkg::*;
#(
   parameter int NUM_ZONES   = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   tfd_chan_if.sink   req_if,
   tfd_chan_if.source rsp_if,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   frame_end_type        frame_end;
   logic [NUM_ZONES-1:0] press_mask;
   logic                 walk_ready;
   logic                 accept;

   assign req_if.ready = walk_ready;
   assign accept       = req_if.valid && walk_ready;

   tfd_deframer #(
      .NUM_ZONES (NUM_ZONES)
   ) u_deframer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_if.payload.rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .frame_end   (frame_end),
      .press_mask  (press_mask)
   );

   tfd_walker #(
      .NUM_ZONES   (NUM_ZONES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .frame_end  (frame_end),
      .press_mask (press_mask),
      .ready      (walk_ready),
      .rsp        (rsp_if)
   );
endmodule

### dv/touch_frame_deframer_press_counter_core_tb.sv
// ----------------------------------------------------------------------------
// touch_frame_deframer_press_counter_core_tb
// Streams received bytes into the deframer: opening corner cases, then
// well-formed touch and other frames with random content, short noise and
// broken frames. Each phase after the opening one first sets a touch threshold. Results are
// checked in order against a local deframer and press counter model, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module touch_frame_deframer_press_counter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tfd_pkg::*;

   localparam int NUM_ZONES   = 32;
   localparam int COUNT_WIDTH = 32;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 40;

   // dropped noise, short frames, 0xFF as data, zero length, touch command
   // with the wrong length
   localparam logic [7:0] OPENING [22] = '{
      8'h00, 8'h7F, 8'hFE,
      8'hFF, 8'h00, 8'h00, 8'h00,
      8'hFF, 8'hFF, 8'h02, 8'hFF, 8'h00, 8'h55,
      8'hFF, 8'h01, 8'h01, 8'hAA, 8'h00,
      8'hFF, 8'h01, 8'h00, 8'hFF
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   tfd_chan_if #(.payload_type(req_payload_type)) req_chan ();
   tfd_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   touch_frame_deframer_press_counter_core #(
      .NUM_ZONES  (NUM_ZONES),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_chan),
      .rsp_if     (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stimulus and bookkeeping
   logic [7:0]      rx_bytes [$];
   rsp_payload_type pending_reports [$];
   int              queued_bytes = 0;
   int              bytes_taken = 0;
   int              reports_checked = 0;
   int              failures = 0;
   int              stall_cycles = 0;
   logic            byte_taken = 1'b0;
   logic            quiet_run = 1'b0;
   logic [7:0]      threshold_plan = THRESHOLD_RESET;

   // deframer model state
   logic [7:0]             threshold_now = THRESHOLD_RESET;
   logic                   synced = 1'b0;
   logic [1:0]             frame_step = PH_CMD;
   logic [7:0]             cmd_hold = '0;
   logic [7:0]             len_hold = '0;
   logic [7:0]             payload_idx = '0;
   logic [NUM_ZONES-1:0]   press_mask = '0;
   logic [COUNT_WIDTH-1:0] press_tally [NUM_ZONES];
   int                     touch_frames = 0;
   int                     other_frames = 0;

   task automatic deframe_byte(input logic [7:0] b);
      rsp_payload_type r;
      if (!synced) begin
         if (b == SYNC_BYTE) begin
            synced = 1'b1;
            frame_step = PH_CMD;
         end
      end else begin
         case (frame_step)
            PH_CMD: begin
               cmd_hold = b;
               frame_step = PH_LEN;
            end
            PH_LEN: begin
               len_hold = b;
               payload_idx = '0;
               press_mask = '0;
               frame_step = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (cmd_hold == TOUCH_CMD && len_hold == TOUCH_LEN &&
                   payload_idx < NUM_ZONES && b >= threshold_now)
                  press_mask[NUM_ZONES - 1 - payload_idx] = 1'b1;
               payload_idx = payload_idx + 8'd1;
               if (payload_idx >= len_hold)
                  frame_step = PH_CHECK;
            end
            default: begin
               // checksum ends the frame; it is never checked
               synced = 1'b0;
               frame_step = PH_CMD;
               if (cmd_hold == TOUCH_CMD && len_hold == TOUCH_LEN) begin
                  touch_frames++;
                  for (int z = 0; z < NUM_ZONES; z++) begin
                     if (press_mask[z]) begin
                        if (press_tally[z] != COUNT_MAX)
                           press_tally[z] = press_tally[z] + 1'b1;
                     end else begin
                        press_tally[z] = '0;
                     end
                     r.result_kind  = KIND_ZONE;
                     r.zone_index   = 5'(z);
                     r.press_count  = press_tally[z][31:0];
                     r.zone_pressed = press_mask[z];
                     r.packet_cmd   = cmd_hold;
                     r.packet_len   = len_hold;
                     r.last         = (z == NUM_ZONES - 1);
                     pending_reports.push_back(r);
                  end
               end else begin
                  other_frames++;
                  r = '0;
                  r.result_kind = KIND_OTHER;
                  r.packet_cmd  = cmd_hold;
                  r.packet_len  = len_hold;
                  r.last        = 1'b1;
                  pending_reports.push_back(r);
               end
               press_mask = '0;
            end
         endcase
      end
   endtask

   task automatic queue_byte(input logic [7:0] b);
      rx_bytes.push_back(b);
      queued_bytes++;
   endtask

   // style: 0 all released, 1 all 0xFF, 2 straddle threshold,
   // 3 mixed corner values, 4 mostly pressed
   task automatic add_touch_frame(input int style);
      logic [7:0] v;
      int pick;
      queue_byte(SYNC_BYTE);
      queue_byte(TOUCH_CMD);
      queue_byte(TOUCH_LEN);
      for (int i = 0; i < NUM_ZONES; i++) begin
         case (style)
            0: v = 8'h00;
            1: v = 8'hFF;
            2: v = (i % 2 == 0) ? threshold_plan - 8'd1 : threshold_plan;
            3: begin
               pick = $urandom_range(5);
               case (pick)
                  0: v = 8'h00;
                  1: v = 8'hFF;
                  2: v = threshold_plan - 8'd1;
                  3: v = threshold_plan;
                  4: v = threshold_plan + 8'd1;
                  default: v = 8'($urandom_range(255));
               endcase
            end
            default: begin
               if ($urandom_range(99) < 85)
                  v = 8'($urandom_range(255, threshold_plan));
               else
                  v = 8'($urandom_range(255));
            end
         endcase
         queue_byte(v);
      end
      queue_byte(8'($urandom_range(255)));
   endtask

   task automatic add_other_frame(input logic [7:0] cmd, input logic [7:0] len);
      queue_byte(SYNC_BYTE);
      queue_byte(cmd);
      queue_byte(len);
      for (int i = 0; i < len; i++)
         queue_byte(8'($urandom_range(255)));
      queue_byte(8'($urandom_range(255)));
   endtask

   task automatic add_random_traffic(input int budget);
      int goal;
      int pick;
      goal = queued_bytes + budget;
      while (queued_bytes < goal) begin
         pick = $urandom_range(99);
         if (pick < 62) begin
            add_touch_frame($urandom_range(99) < 50 ? 4 : 3);
         end else if (pick < 78) begin
            add_other_frame(8'($urandom_range(255)), 8'($urandom_range(6)));
         end else if (pick < 88) begin
            // one field off from a touch frame
            case ($urandom_range(3))
               0: add_other_frame(TOUCH_CMD, TOUCH_LEN - 8'd1);
               1: add_other_frame(TOUCH_CMD, TOUCH_LEN + 8'd1);
               2: add_other_frame(8'h00, TOUCH_LEN);
               default: add_other_frame(8'h02, TOUCH_LEN);
            endcase
         end else begin
            // noise between frames; a 0xFF in it starts a frame of its own
            repeat ($urandom_range(4, 1))
               queue_byte(8'($urandom_range(255)));
         end
      end
   endtask

   task automatic wait_drained();
      while (rx_bytes.size() != 0 || req_chan.valid || pending_reports.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_threshold(input logic [7:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      threshold_plan = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !byte_taken) begin
         // hold until accepted
      end else if (rx_bytes.size() != 0 && (quiet_run || $urandom_range(99) >= 8)) begin
         req_chan.valid <= 1'b1;
         req_chan.payload.rx_byte <= rx_bytes.pop_front();
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // result receiver
   always @(negedge clock) begin
      rsp_chan.ready <= quiet_run || ($urandom_range(99) >= 8);
   end

   // monitor, model update and result check
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      byte_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (csr_wr_en)
            threshold_now = csr_wr_data;
         if (req_chan.valid && req_chan.ready) begin
            deframe_byte(req_chan.payload.rx_byte);
            bytes_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (pending_reports.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t unexpected result: kind %0d zone %0d count %0d cmd %02h",
                           $realtime, got.result_kind, got.zone_index, got.press_count,
                           got.packet_cmd);
            end else begin
               want = pending_reports.pop_front();
               reports_checked++;
               if (got.result_kind !== want.result_kind ||
                   got.zone_index !== want.zone_index ||
                   got.press_count !== want.press_count ||
                   got.zone_pressed !== want.zone_pressed ||
                   got.packet_cmd !== want.packet_cmd ||
                   got.packet_len !== want.packet_len ||
                   got.last !== want.last) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%0t result mismatch: expected kind %0d zone %0d count %0d",
                              $realtime, want.result_kind, want.zone_index,
                              want.press_count);
                     $display("   expected pressed %0d cmd %02h len %02h last %0d",
                              want.zone_pressed, want.packet_cmd, want.packet_len,
                              want.last);
                     $display("   got kind %0d zone %0d count %0d pressed %0d",
                              got.result_kind, got.zone_index, got.press_count,
                              got.zone_pressed);
                     $display("   got cmd %02h len %02h last %0d",
                              got.packet_cmd, got.packet_len, got.last);
                  end
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("FAIL touch_frame_deframer_press_counter_core");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [7:0] thresholds [7];
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      for (int z = 0; z < NUM_ZONES; z++)
         press_tally[z] = '0;
      thresholds = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'($urandom_range(255)), 8'hFE,
                     8'($urandom_range(255))};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // opening corner cases at the reset threshold
      foreach (OPENING[i])
         queue_byte(OPENING[i]);
      add_touch_frame(1);
      add_touch_frame(1);
      add_touch_frame(2);
      add_touch_frame(0);

      foreach (thresholds[i]) begin
         write_threshold(thresholds[i]);
         // run one phase with no idling on either side
         quiet_run = (i == 2);
         if (i == 3)
            add_other_frame(8'h5A, 8'h30);
         add_random_traffic(quiet_run ? 40 : 4);
      end

      wait_drained();
      quiet_run = 1'b0;
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_reports.size() != 0) begin
         failures += pending_reports.size();
         $display("%0d expected results never arrived", pending_reports.size());
      end
      $display("Covered %0d bytes over %0d touch and %0d other frames at 8 thresholds,",
               bytes_taken, touch_frames, other_frames);
      $display("with %0d results checked and %0d failures.", reports_checked, failures);
      if (failures == 0)
         $display("PASS touch_frame_deframer_press_counter_core");
      else
         $display("FAIL touch_frame_deframer_press_counter_core");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/tfd_pkg.sv
rtl/tfd_chan_if.sv
rtl/tfd_ram.sv
rtl/tfd_deframer.sv
rtl/tfd_walker.sv
rtl/touch_frame_deframer_press_counter_core.sv
dv/touch_frame_deframer_press_counter_core_tb.sv
